// ----- rtl/aggregation_walker_grid_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the aggregation walker grid unit
// Concurrent assertion forms shared by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef AGGREGATION_WALKER_GRID_UNIT_ASSERT_SVH
`define AGGREGATION_WALKER_GRID_UNIT_ASSERT_SVH

// condition holds at every sampled edge
`define AWG_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("awg: invariant violated");

// same-cycle implication
`define AWG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("awg: implication violated");

// next-cycle implication
`define AWG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("awg: next-cycle implication violated");

`endif

// ----- rtl/awg_pkg.sv -----
// ----------------------------------------------------------------------------
// awg_pkg
// Types, codes and sizes for the aggregation walker grid unit.
// ----------------------------------------------------------------------------
`default_nettype none

package awg_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int MAX_WALKERS = 4096;
  localparam int MIN_DIM     = 4;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int SLOT_W   = $clog2(MAX_WALKERS);
  localparam int COUNT_W  = $clog2(MAX_WALKERS + 1);
  localparam int DIM_W    = 9;
  localparam int WALKER_W = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_WALKERS);
  localparam logic [DIM_W-1:0]   DIM_MIN   = DIM_W'(MIN_DIM);
  localparam logic [DIM_W-1:0]   WIDTH_MAX = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]   HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

  // item modes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_SEED  = 2'd1;
  localparam logic [1:0] MODE_ADD   = 2'd2;
  localparam logic [1:0] MODE_STEP  = 2'd3;

  // step directions
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // result status
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_STUCK  = 2'd1;
  localparam logic [1:0] STATUS_REJECT = 2'd2;
  localparam logic [1:0] STATUS_EMPTY  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_WLOAD,
    S_CHECK,
    S_MARK_RD,
    S_MARK_WR,
    S_LAST_RD,
    S_LAST_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [1:0] direction;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         cell_x;
    logic [7:0]         cell_y;
    logic [COUNT_W-1:0] walkers_left;
    logic               pass_end;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/aggregation_walker_grid_unit.sv -----
// ----------------------------------------------------------------------------
// aggregation_walker_grid_unit
// Diffusion-limited aggregation engine: one-bit sticky grid, walker table,
// single row read-modify-write unit driven by a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | signals                         | direction | payload
//  --------+---------------------------------+-----------+-----------------
//  in      | in_valid / in_stall / in_item   | into unit | mode, pos, dir
//  out     | out_valid / out_stall / out_item| out of it | status, cell, count
//  cfg     | cfg_we / cfg_index / cfg_data   | into unit | grid width/height
//
//  One item at a time. Clear and add go from START straight to DONE; a plain
//  step passes WLOAD and CHECK, an in-range seed CHECK and the mark states,
//  a stick WLOAD, CHECK, the mark states, LAST_RD and LAST_WR. DONE loads the
//  output register, and the next item is accepted in IDLE. The single-port row
//  memory sets the pace: each marked row costs one read and one write.
//  rst is synchronous; it and mode 0 clear all row valid bits at once, so no
//  clearing pass over the grid memory is needed.
//  A result waits in the output register while the next item is accepted;
//  only a second finished result waits for out_stall to drop.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aggregation_walker_grid_unit_assert.svh"

module aggregation_walker_grid_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire awg_pkg::in_t                         in_item,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output awg_pkg::out_t                             out_item,
  input  wire logic                                 cfg_we,
  input  wire logic [awg_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [awg_pkg::DIM_W-1:0]            cfg_data
);

  // --------------------------------------------------------------------------
  // Sequencer and working registers
  // --------------------------------------------------------------------------
  awg_pkg::state_t state, state_next;
  awg_pkg::in_t    item;

  logic [awg_pkg::DIM_W-1:0]   grid_width, grid_height;
  logic [awg_pkg::DIM_W-1:0]   used_w, used_h, w_m2, h_m2;

  logic [awg_pkg::COUNT_W-1:0] count, count_next;
  logic [awg_pkg::SLOT_W-1:0]  cursor, cursor_next;
  logic [awg_pkg::SLOT_W-1:0]  slot, slot_next;
  logic [awg_pkg::COL_W-1:0]   cx, cx_next;
  logic [awg_pkg::ROW_W-1:0]   cy, cy_next;
  logic [1:0]                  k, k_next;          // marked row offset 0..2
  logic [1:0]                  res_status, res_status_next;
  logic                        res_pend, res_pend_next;

  logic [awg_pkg::COUNT_W-1:0] cursor_wide, slot_inc, count_dec;
  logic                        out_free;

  // --------------------------------------------------------------------------
  // Grid memory: one row of cells per word; row valid bits stand in for a
  // clear. Walker memory: {y, x} per slot.
  // --------------------------------------------------------------------------
  logic [awg_pkg::MAX_WIDTH-1:0] grid_mem [awg_pkg::MAX_HEIGHT];
  logic [awg_pkg::MAX_WIDTH-1:0] grid_q, grid_wdata, row_data;
  logic [awg_pkg::MAX_HEIGHT-1:0] row_valid;
  logic                           grid_q_valid;
  logic                           grid_rd_en, grid_we, row_clear;
  logic [awg_pkg::ROW_W-1:0]      grid_addr;

  logic [awg_pkg::WALKER_W-1:0]   walk_mem [awg_pkg::MAX_WALKERS];
  logic [awg_pkg::WALKER_W-1:0]   walk_q, walk_wdata;
  logic                           walk_rd_en, walk_we;
  logic [awg_pkg::SLOT_W-1:0]     walk_addr;

  // neighborhood datapath
  logic                           cell_hit;
  logic [awg_pkg::DIM_W-1:0]      row_sum, row_m1;
  logic                           mark_row_ok;
  logic [awg_pkg::ROW_W-1:0]      mark_row;
  logic [awg_pkg::MAX_WIDTH-1:0]  mark_mask;
  logic [awg_pkg::DIM_W-1:0]      col_sum, col_m1;
  logic [awg_pkg::COL_W-1:0]      move_x;
  logic [awg_pkg::ROW_W-1:0]      move_y;
  logic                           add_bad;

  // --------------------------------------------------------------------------
  // Saturated grid size and interior bounds
  // --------------------------------------------------------------------------
  always_comb begin
    priority if (grid_width < awg_pkg::DIM_MIN) begin
      used_w = awg_pkg::DIM_MIN;
    end else if (grid_width > awg_pkg::WIDTH_MAX) begin
      used_w = awg_pkg::WIDTH_MAX;
    end else begin
      used_w = grid_width;
    end
    priority if (grid_height < awg_pkg::DIM_MIN) begin
      used_h = awg_pkg::DIM_MIN;
    end else if (grid_height > awg_pkg::HEIGHT_MAX) begin
      used_h = awg_pkg::HEIGHT_MAX;
    end else begin
      used_h = grid_height;
    end
  end

  assign w_m2 = used_w - awg_pkg::DIM_W'(2);
  assign h_m2 = used_h - awg_pkg::DIM_W'(2);

  assign cursor_wide = {1'b0, cursor};
  assign slot_inc    = {1'b0, slot} + awg_pkg::COUNT_W'(1);
  assign count_dec   = count - awg_pkg::COUNT_W'(1);
  assign out_free    = !out_valid || !out_stall;

  // new walker must sit in the interior and find a free slot
  assign add_bad = (item.pos_x == '0) || ({1'b0, item.pos_x} > w_m2) ||
                   (item.pos_y == '0) || ({1'b0, item.pos_y} > h_m2) ||
                   (count >= awg_pkg::MAX_COUNT);

  // row word as stored, or all zero if the row was not written since clear
  assign row_data = grid_q_valid ? grid_q : '0;
  assign cell_hit = row_data[cx];

  // row cy-1+k, dropped when above row 0 or below the used height
  assign row_sum     = {1'b0, cy} + awg_pkg::DIM_W'(k);
  assign row_m1      = row_sum - awg_pkg::DIM_W'(1);
  assign mark_row_ok = (row_sum != '0) && (row_m1 < used_h);
  assign mark_row    = row_m1[awg_pkg::ROW_W-1:0];

  // columns cx-1..cx+1 clipped to the used width; centre is harmless for a
  // stick since that cell is already set
  always_comb begin
    mark_mask = '0;
    col_sum   = '0;
    col_m1    = '0;
    for (int j = 0; j < 3; j++) begin
      col_sum = {1'b0, cx} + awg_pkg::DIM_W'(j);
      col_m1  = col_sum - awg_pkg::DIM_W'(1);
      if ((col_sum != '0) && (col_m1 < used_w)) begin
        mark_mask[col_m1[awg_pkg::COL_W-1:0]] = 1'b1;
      end
    end
  end

  // one random step, held at the interior edge
  always_comb begin
    move_x = cx;
    move_y = cy;
    unique case (item.direction)
      awg_pkg::DIR_LEFT: begin
        if (cx > awg_pkg::COL_W'(1)) move_x = cx - awg_pkg::COL_W'(1);
      end
      awg_pkg::DIR_RIGHT: begin
        if ({1'b0, cx} < w_m2) move_x = cx + awg_pkg::COL_W'(1);
      end
      awg_pkg::DIR_UP: begin
        if (cy > awg_pkg::ROW_W'(1)) move_y = cy - awg_pkg::ROW_W'(1);
      end
      awg_pkg::DIR_DOWN: begin
        if ({1'b0, cy} < h_m2) move_y = cy + awg_pkg::ROW_W'(1);
      end
      default: begin
        move_x = cx;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Next state and control
  // --------------------------------------------------------------------------
  always_comb begin
    state_next      = state;
    count_next      = count;
    cursor_next     = cursor;
    slot_next       = slot;
    cx_next         = cx;
    cy_next         = cy;
    k_next          = k;
    res_status_next = res_status;
    res_pend_next   = res_pend;
    in_stall        = (state != awg_pkg::S_IDLE);
    grid_rd_en      = 1'b0;
    grid_we         = 1'b0;
    grid_addr       = mark_row;
    grid_wdata      = row_data | mark_mask;
    row_clear       = 1'b0;
    walk_rd_en      = 1'b0;
    walk_we         = 1'b0;
    walk_addr       = slot;
    walk_wdata      = {move_y, move_x};

    unique case (state)
      awg_pkg::S_IDLE: begin
        if (in_valid) state_next = awg_pkg::S_START;
      end

      awg_pkg::S_START: begin
        cx_next         = '0;
        cy_next         = '0;
        res_pend_next   = 1'b0;
        res_status_next = awg_pkg::STATUS_OK;
        state_next      = awg_pkg::S_DONE;
        unique case (item.mode)
          awg_pkg::MODE_CLEAR: begin
            row_clear   = 1'b1;
            count_next  = '0;
            cursor_next = '0;
          end
          awg_pkg::MODE_SEED: begin
            cx_next = item.pos_x;
            cy_next = item.pos_y;
            if (({1'b0, item.pos_x} >= used_w) || ({1'b0, item.pos_y} >= used_h)) begin
              res_status_next = awg_pkg::STATUS_REJECT;
            end else begin
              grid_rd_en = 1'b1;
              grid_addr  = item.pos_y;
              state_next = awg_pkg::S_CHECK;
            end
          end
          awg_pkg::MODE_ADD: begin
            cx_next = item.pos_x;
            cy_next = item.pos_y;
            if (add_bad) begin
              res_status_next = awg_pkg::STATUS_REJECT;
            end else begin
              walk_we    = 1'b1;
              walk_addr  = count[awg_pkg::SLOT_W-1:0];
              walk_wdata = {item.pos_y, item.pos_x};
              count_next = count + awg_pkg::COUNT_W'(1);
            end
          end
          awg_pkg::MODE_STEP: begin
            if (count == '0) begin
              res_status_next = awg_pkg::STATUS_EMPTY;
              cursor_next     = '0;
            end else begin
              slot_next  = (cursor_wide >= count) ? '0 : cursor;
              walk_rd_en = 1'b1;
              walk_addr  = slot_next;
              state_next = awg_pkg::S_WLOAD;
            end
          end
          default: begin
            state_next = awg_pkg::S_DONE;
          end
        endcase
      end

      awg_pkg::S_WLOAD: begin
        cx_next    = walk_q[awg_pkg::COL_W-1:0];
        cy_next    = walk_q[awg_pkg::WALKER_W-1:awg_pkg::COL_W];
        grid_rd_en = 1'b1;
        grid_addr  = walk_q[awg_pkg::WALKER_W-1:awg_pkg::COL_W];
        state_next = awg_pkg::S_CHECK;
      end

      awg_pkg::S_CHECK: begin
        k_next = '0;
        if (item.mode == awg_pkg::MODE_SEED) begin
          if (cell_hit) begin
            res_status_next = awg_pkg::STATUS_REJECT;
            state_next      = awg_pkg::S_DONE;
          end else begin
            state_next = awg_pkg::S_MARK_RD;
          end
        end else if (cell_hit) begin
          res_status_next = awg_pkg::STATUS_STUCK;
          state_next      = awg_pkg::S_MARK_RD;
        end else begin
          cx_next    = move_x;
          cy_next    = move_y;
          walk_we    = 1'b1;
          walk_addr  = slot;
          walk_wdata = {move_y, move_x};
          if (slot_inc >= count) begin
            cursor_next   = '0;
            res_pend_next = 1'b1;
          end else begin
            cursor_next = slot_inc[awg_pkg::SLOT_W-1:0];
          end
          state_next = awg_pkg::S_DONE;
        end
      end

      awg_pkg::S_MARK_RD: begin
        if (mark_row_ok) begin
          grid_rd_en = 1'b1;
          state_next = awg_pkg::S_MARK_WR;
        end else if (k == 2'd2) begin
          state_next = (item.mode == awg_pkg::MODE_SEED) ? awg_pkg::S_DONE
                                                         : awg_pkg::S_LAST_RD;
        end else begin
          k_next = k + 2'd1;
        end
      end

      awg_pkg::S_MARK_WR: begin
        grid_we = 1'b1;
        if (k == 2'd2) begin
          state_next = (item.mode == awg_pkg::MODE_SEED) ? awg_pkg::S_DONE
                                                         : awg_pkg::S_LAST_RD;
        end else begin
          k_next     = k + 2'd1;
          state_next = awg_pkg::S_MARK_RD;
        end
      end

      awg_pkg::S_LAST_RD: begin
        count_next = count_dec;
        walk_rd_en = 1'b1;
        walk_addr  = count_dec[awg_pkg::SLOT_W-1:0];
        state_next = awg_pkg::S_LAST_WR;
      end

      awg_pkg::S_LAST_WR: begin
        walk_we    = 1'b1;
        walk_addr  = slot;
        walk_wdata = walk_q;
        if (slot_inc >= count) begin
          cursor_next   = '0;
          res_pend_next = 1'b1;
        end else begin
          cursor_next = slot_inc[awg_pkg::SLOT_W-1:0];
        end
        state_next = awg_pkg::S_DONE;
      end

      awg_pkg::S_DONE: begin
        if (out_free) state_next = awg_pkg::S_IDLE;
      end

      default: begin
        state_next = awg_pkg::S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= awg_pkg::S_IDLE;
      count       <= '0;
      cursor      <= '0;
      grid_width  <= awg_pkg::WIDTH_MAX;
      grid_height <= awg_pkg::HEIGHT_MAX;
    end else begin
      state  <= state_next;
      count  <= count_next;
      cursor <= cursor_next;
      if (cfg_we) begin
        unique case (cfg_index)
          awg_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
          awg_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
          default: grid_width <= grid_width;
        endcase
      end
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) item <= in_item;
    slot       <= slot_next;
    cx         <= cx_next;
    cy         <= cy_next;
    k          <= k_next;
    res_status <= res_status_next;
    res_pend   <= res_pend_next;
  end

  // row valid bits: cleared together, set per row on write
  always_ff @(posedge clk) begin
    if (rst || row_clear) begin
      row_valid <= '0;
    end else if (grid_we) begin
      row_valid[grid_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_addr] <= grid_wdata;
    if (grid_rd_en) begin
      grid_q       <= grid_mem[grid_addr];
      grid_q_valid <= row_valid[grid_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (walk_we) walk_mem[walk_addr] <= walk_wdata;
    if (walk_rd_en) walk_q <= walk_mem[walk_addr];
  end

  // --------------------------------------------------------------------------
  // Output register: one finished transaction may wait here
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == awg_pkg::S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == awg_pkg::S_DONE) && out_free) begin
      out_item.status       <= res_status;
      out_item.cell_x       <= cx;
      out_item.cell_y       <= cy;
      out_item.walkers_left <= count;
      out_item.pass_end     <= res_pend;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `AWG_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= awg_pkg::MAX_COUNT)
  `AWG_ASSERT_IMPL(a_cursor_range, clk, rst, state == awg_pkg::S_IDLE, (cursor == '0) || (cursor_wide < count))
  `AWG_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && !in_stall, state != awg_pkg::S_IDLE)

endmodule

`default_nettype wire
